@@ rtl/core/gray_code_edge_subset_enumerator_defines.svh @@
// Assertion macros used by the checker file of the enumerator.
`ifndef GRAY_CODE_EDGE_SUBSET_ENUMERATOR_DEFINES_SVH
`define GRAY_CODE_EDGE_SUBSET_ENUMERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCES_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GCES_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ rtl/core/gces_pkg.sv @@
// ----------------------------------------------------------------------------
// gces_pkg
// Shared widths, command type and the triangular number table of the
// Gray code edge subset enumerator.
// ----------------------------------------------------------------------------
package gces_pkg;

  localparam int VC_W  = 4;   // vertex count and vertex query width
  localparam int IDX_W = 7;   // edge index, edge count and popcount width
  localparam int CNT_W = 64;  // subset ordinal width

  typedef struct packed {
    logic capture;  // latch the request payload
    logic step;     // run one advance step on the walk state
    logic load;     // load the result register
  } gces_cmd_t;

  // n(n-1)/2 for a 4-bit n: the edge count of n vertices and also the
  // index of the first edge in triangular row n.
  function automatic logic [IDX_W-1:0] tri_base(input logic [VC_W-1:0] n);
    logic [IDX_W-1:0] t;
    unique case (n)
      4'd0:    t = 7'd0;
      4'd1:    t = 7'd0;
      4'd2:    t = 7'd1;
      4'd3:    t = 7'd3;
      4'd4:    t = 7'd6;
      4'd5:    t = 7'd10;
      4'd6:    t = 7'd15;
      4'd7:    t = 7'd21;
      4'd8:    t = 7'd28;
      4'd9:    t = 7'd36;
      4'd10:   t = 7'd45;
      4'd11:   t = 7'd55;
      4'd12:   t = 7'd66;
      4'd13:   t = 7'd78;
      4'd14:   t = 7'd91;
      4'd15:   t = 7'd105;
      default: t = 7'd0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/gces_if.sv @@
// ----------------------------------------------------------------------------
// gces_if
// Channel interfaces of the enumerator: request, result and configuration.
// ----------------------------------------------------------------------------
interface gces_req_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [gces_pkg::VC_W-1:0]  query_row;
  logic [gces_pkg::VC_W-1:0]  query_col;

  modport source (output valid, output func, output query_row, output query_col,
                  input ready);
  modport sink   (input valid, input func, input query_row, input query_col,
                  output ready);
endinterface

interface gces_rsp_if #(parameter int EDGE_BITS = 64);
  logic                        valid;
  logic                        ready;
  logic                        advanced;
  logic [gces_pkg::IDX_W-1:0]  flip_index;
  logic [EDGE_BITS-1:0]        edge_bits;
  logic [gces_pkg::IDX_W-1:0]  edge_total;
  logic [gces_pkg::CNT_W-1:0]  subset_number;
  logic                        adjacent;

  modport source (output valid, output advanced, output flip_index, output edge_bits,
                  output edge_total, output subset_number, output adjacent,
                  input ready);
  modport sink   (input valid, input advanced, input flip_index, input edge_bits,
                  input edge_total, input subset_number, input adjacent,
                  output ready);
endinterface

interface gces_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [gces_pkg::VC_W-1:0]  vertex_count;

  modport source (output valid, output vertex_count, input ready);
  modport sink   (input valid, input vertex_count, output ready);
endinterface

@@ rtl/core/gces_ctrl.sv @@
// ----------------------------------------------------------------------------
// gces_ctrl
// Sequencer of the enumerator: accepts a request, runs the step cycle, then
// the report cycle that loads the result register.
// ----------------------------------------------------------------------------
module gces_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output gces_pkg::gces_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_STEP   = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_valid_next;
  logic       load_ok;
  logic       accept;

  // The result register is free when empty or when its content is taken now.
  assign load_ok   = (state == ST_REPORT) && (!rsp_valid || rsp_ready);
  assign req_ready = (state == ST_IDLE) || load_ok;
  assign accept    = req_valid && req_ready;

  assign cmd.capture = accept;
  assign cmd.step    = (state == ST_STEP);
  assign cmd.load    = load_ok;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_STEP;
      end
      ST_STEP: begin
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (load_ok) state_next = accept ? ST_STEP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_ok) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

@@ rtl/core/gces_datapath.sv @@
// ----------------------------------------------------------------------------
// gces_datapath
// Walk state, Gray code step logic and the result register with popcount
// and adjacency lookup.
// ----------------------------------------------------------------------------
module gces_datapath #(
  parameter int EDGE_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gces_pkg::VC_W-1:0]   cfg_vertex_count,
  input  logic                        req_func,
  input  logic [gces_pkg::VC_W-1:0]   req_query_row,
  input  logic [gces_pkg::VC_W-1:0]   req_query_col,
  input  gces_pkg::gces_cmd_t         cmd,
  output logic                        advanced,
  output logic [gces_pkg::IDX_W-1:0]  flip_index,
  output logic [EDGE_BITS-1:0]        edge_bits,
  output logic [gces_pkg::IDX_W-1:0]  edge_total,
  output logic [gces_pkg::CNT_W-1:0]  subset_number,
  output logic                        adjacent
);

  localparam int IW = gces_pkg::IDX_W;
  localparam logic [IW-1:0] EDGE_LIMIT = IW'(EDGE_BITS);

  // Walk state and configuration
  logic [gces_pkg::VC_W-1:0]  vertex_count;
  logic [IW-1:0]              edge_count;
  logic [EDGE_BITS-1:0]       edge_vector;
  logic                       parity_bit;
  logic [IW-1:0]              last_flip;
  logic [gces_pkg::CNT_W-1:0] subset_counter;
  logic                       step_adv;

  // Latched request
  logic                       func_q;
  logic [gces_pkg::VC_W-1:0]  row_q;
  logic [gces_pkg::VC_W-1:0]  col_q;

  logic [IW-1:0]              edge_count_next;
  logic [EDGE_BITS-1:0]       mask;
  logic [EDGE_BITS-1:0]       masked;
  logic [IW-1:0]              low_idx;
  logic                       do_step;
  logic                       parity_next;
  logic [IW-1:0]              flip_sel;
  logic                       flip_ok;
  logic [EDGE_BITS-1:0]       flip_vec;
  logic [IW-1:0]              pop;
  logic                       adj;

  always_comb begin
    edge_count_next = gces_pkg::tri_base(cfg_vertex_count);
    if (edge_count_next > EDGE_LIMIT) edge_count_next = EDGE_LIMIT;
  end

  always_comb begin
    for (int i = 0; i < EDGE_BITS; i++) begin
      mask[i] = (IW'(i) < edge_count);
    end
    masked = edge_vector & mask;
  end

  // Lowest set edge; the edge count when none is set.
  always_comb begin
    low_idx = edge_count;
    for (int i = EDGE_BITS - 1; i >= 0; i--) begin
      if (masked[i]) low_idx = IW'(i);
    end
  end

  always_comb begin
    do_step     = cmd.step && !func_q && (last_flip < edge_count);
    parity_next = ~parity_bit;
    flip_sel    = parity_next ? '0 : low_idx + IW'(1);
    flip_ok     = flip_sel < edge_count;
    for (int i = 0; i < EDGE_BITS; i++) begin
      flip_vec[i] = flip_ok && (flip_sel == IW'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count   <= gces_pkg::VC_W'(1);
      edge_count     <= '0;
      edge_vector    <= '0;
      parity_bit     <= 1'b0;
      last_flip      <= '0;
      subset_counter <= gces_pkg::CNT_W'(1);
      step_adv       <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_vertex_count;
        edge_count   <= edge_count_next;
      end
      if (cmd.step) step_adv <= do_step && flip_ok;
      if (do_step) begin
        parity_bit  <= parity_next;
        last_flip   <= flip_sel;
        edge_vector <= edge_vector ^ flip_vec;
        if (flip_ok) subset_counter <= subset_counter + gces_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= req_func;
      row_q  <= req_query_row;
      col_q  <= req_query_col;
    end
  end

  always_comb begin
    pop = '0;
    for (int i = 0; i < EDGE_BITS; i++) begin
      pop = pop + IW'(masked[i]);
    end
  end

  // Symmetric lookup: edge between hi and lo sits at hi(hi-1)/2 + lo.
  always_comb begin
    logic [gces_pkg::VC_W-1:0] hi;
    logic [gces_pkg::VC_W-1:0] lo;
    logic [IW-1:0]             k;
    hi  = (row_q > col_q) ? row_q : col_q;
    lo  = (row_q > col_q) ? col_q : row_q;
    k   = gces_pkg::tri_base(hi) + IW'(lo);
    adj = 1'b0;
    if ((row_q != col_q) && (row_q < vertex_count) && (col_q < vertex_count)
        && (k < edge_count)) begin
      for (int i = 0; i < EDGE_BITS; i++) begin
        if (k == IW'(i)) adj = masked[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      advanced      <= step_adv;
      flip_index    <= last_flip;
      edge_bits     <= masked;
      edge_total    <= pop;
      subset_number <= subset_counter;
      adjacent      <= adj;
    end
  end

endmodule

@@ rtl/core/gray_code_edge_subset_enumerator.sv @@
// Gray code edge subset enumerator. Each request either advances the walk
// over all edge subsets of a graph on vertex_count vertices by one Gray code
// step (func 0) or only reports the current subset (func 1); either way one
// result follows, carrying the subset, its edge count, its ordinal, the last
// flipped index and the adjacency bit for the queried row and column. A
// request passes through the step stage (priority encode over the edge
// vector) and then the report stage (popcount and adjacency lookup into the
// result register); the next request is taken in the report state once the
// result register is free, so a new request overlaps the report of the last.
// Configuration writes are always ready and take effect at once.

// ----------------------------------------------------------------------------
// gray_code_edge_subset_enumerator
// Top level: joins the sequencer and the datapath to the channels.
// ----------------------------------------------------------------------------
module gray_code_edge_subset_enumerator #(
  parameter int EDGE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  gces_req_if.sink    req,
  gces_rsp_if.source  rsp,
  gces_cfg_if.sink    cfg
);

  gces_pkg::gces_cmd_t cmd;
  logic                req_ready;
  logic                rsp_valid;

  assign cfg.ready = 1'b1;
  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

  gces_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  gces_datapath #(
    .EDGE_BITS (EDGE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg.valid),
    .cfg_vertex_count (cfg.vertex_count),
    .req_func         (req.func),
    .req_query_row    (req.query_row),
    .req_query_col    (req.query_col),
    .cmd              (cmd),
    .advanced         (rsp.advanced),
    .flip_index       (rsp.flip_index),
    .edge_bits        (rsp.edge_bits),
    .edge_total       (rsp.edge_total),
    .subset_number    (rsp.subset_number),
    .adjacent         (rsp.adjacent)
  );

endmodule

@@ rtl/core/gces_checker.sv @@
// ----------------------------------------------------------------------------
// gces_checker
// Port-level checks of the enumerator, bound to the top level.
// ----------------------------------------------------------------------------
`include "gray_code_edge_subset_enumerator_defines.svh"

module gces_checker #(
  parameter int EDGE_BITS = 64
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_advanced,
  input logic [gces_pkg::IDX_W-1:0]  rsp_flip_index,
  input logic [EDGE_BITS-1:0]        rsp_edge_bits,
  input logic [gces_pkg::IDX_W-1:0]  rsp_edge_total,
  input logic [gces_pkg::CNT_W-1:0]  rsp_subset_number
);

  localparam logic [gces_pkg::IDX_W-1:0] EDGE_LIMIT = gces_pkg::IDX_W'(EDGE_BITS);

  // A stalled result stays offered and unchanged.
  `GCES_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_edge_bits) && $stable(rsp_subset_number))

  // A request always spends its step cycle before the next one is taken.
  `GCES_ASSERT_NXT(a_req_gap, clk, rst, req_valid && req_ready, !req_ready)

  // A real advance flips an edge that exists.
  `GCES_ASSERT_IMP(a_adv_index, clk, rst, rsp_valid && rsp_advanced, rsp_flip_index < EDGE_LIMIT)

  `GCES_ASSERT_IMP(a_total_range, clk, rst, rsp_valid, rsp_edge_total <= EDGE_LIMIT)

endmodule

bind gray_code_edge_subset_enumerator gces_checker #(
  .EDGE_BITS (EDGE_BITS)
) u_gces_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_advanced      (rsp.advanced),
  .rsp_flip_index    (rsp.flip_index),
  .rsp_edge_bits     (rsp.edge_bits),
  .rsp_edge_total    (rsp.edge_total),
  .rsp_subset_number (rsp.subset_number)
);
